// ===== hw/rtl/lss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg: shared types and codes of the LIFO stack with search
// Request codes, status codes, field widths and the result record.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int DEPTH_DEF = 128;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 8;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  localparam logic [ACTION_W-1:0] ACT_PUSH    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PEEK    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SEARCH  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_REVERSE = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic        [COUNT_W-1:0]  count;
    logic        [POS_W-1:0]    position;
    logic signed [VALUE_W-1:0]  top_value;
    logic        [STATUS_W-1:0] status;
  } res_t;

endpackage

// ===== hw/rtl/lss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/lss_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_out_reg: result output register
// Holds one finished result until it is taken; a new result is accepted while empty or being read out.
// ----------------------------------------------------------------------------
module lss_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  lss_pkg::res_t res,
  output logic          res_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lss_pkg::res_t out_res
);

  logic          valid_r;
  logic          valid_nxt;
  lss_pkg::res_t res_r;

  assign res_ready = !valid_r || out_ready;
  assign valid_nxt = res_ready ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== hw/rtl/lifo_stack_with_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search: LIFO stack of 32-bit words with search and reverse
// Push, pop, clear, unused codes and refused requests: result registered in the cycle
//   after the input transfer; one request per cycle unless the output stalls. Peek:
//   RAM read register, then output register. Search: one stored word per cycle through
//   the RAM read port, result via S_RESP. Reverse: each pair is swapped through S_RV_A,
//   S_RV_B and S_RV_C, then S_RESP. The next request waits for the registered result.
// Reset clears the state and the entry count; the word store is not cleared.
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
  parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] action, [34:3] value, [39:35] zero
  input  logic [lss_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [33:2] top_value, [41:34] position, [49:42] count, [55:50] zero
  output logic [lss_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = lss_pkg::VALUE_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PEEK = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_RV_A = 3'd3;
  localparam logic [2:0] S_RV_B = 3'd4;
  localparam logic [2:0] S_RV_C = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [VW-1:0] key_r, key_nxt;
  logic [VW-1:0] tmp_r, tmp_nxt;
  logic [CW-1:0] pos_r, pos_nxt;

  logic [lss_pkg::ACTION_W-1:0] in_act;
  logic [VW-1:0]                in_val;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata;

  logic                           res_valid, res_ready;
  logic [lss_pkg::STATUS_W-1:0]   res_status;
  logic [VW-1:0]                  res_top;
  logic [CW-1:0]                  res_pos;
  logic [CW+7:0]                  res_pos_ext, res_cnt_ext;
  lss_pkg::res_t                  res, out_res;

  logic          empty, full;
  logic [AW-1:0] top_idx;
  logic [CW-1:0] idx_inc;
  logic [AW:0]   lo_plus2;

  assign in_act = in_tdata[2:0];
  assign in_val = in_tdata[34:3];

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(DEPTH));
  assign top_idx  = AW'(cnt_r - 1'b1);
  assign idx_inc  = CW'(idx_r) + CW'(1);
  assign lo_plus2 = {1'b0, idx_r} + (AW + 1)'(2);

  assign in_tready = (state_r == S_IDLE) && res_ready;

  lss_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    hi_nxt     = hi_r;
    key_nxt    = key_r;
    tmp_nxt    = tmp_r;
    pos_nxt    = pos_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    re         = 1'b0;
    raddr      = '0;
    res_valid  = 1'b0;
    res_status = lss_pkg::ST_DONE;
    res_top    = '0;
    res_pos    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && res_ready) begin
          case (in_act)
            lss_pkg::ACT_PUSH: begin
              res_valid = 1'b1;
              if (full) begin
                res_status = lss_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = cnt_r[AW-1:0];
                wdata   = in_val;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            lss_pkg::ACT_POP: begin
              res_valid = 1'b1;
              if (empty) begin
                res_status = lss_pkg::ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            lss_pkg::ACT_CLEAR: begin
              res_valid = 1'b1;
              if (empty) begin
                res_status = lss_pkg::ST_EMPTY;
              end else begin
                cnt_nxt = '0;
              end
            end
            lss_pkg::ACT_PEEK: begin
              if (empty) begin
                res_valid  = 1'b1;
                res_status = lss_pkg::ST_EMPTY;
              end else begin
                re        = 1'b1;
                raddr     = top_idx;
                state_nxt = S_PEEK;
              end
            end
            lss_pkg::ACT_SEARCH: begin
              if (empty) begin
                res_valid  = 1'b1;
                res_status = lss_pkg::ST_EMPTY;
              end else begin
                re        = 1'b1;
                raddr     = '0;
                idx_nxt   = '0;
                key_nxt   = in_val;
                state_nxt = S_SRCH;
              end
            end
            lss_pkg::ACT_REVERSE: begin
              if (empty) begin
                res_valid  = 1'b1;
                res_status = lss_pkg::ST_EMPTY;
              end else if (cnt_r == CW'(1)) begin
                // A single word is already its own reverse.
                res_valid = 1'b1;
              end else begin
                re        = 1'b1;
                raddr     = '0;
                idx_nxt   = '0;
                hi_nxt    = top_idx;
                pos_nxt   = '0;
                state_nxt = S_RV_A;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_PEEK: begin
        // The read register holds its word while the result waits.
        res_valid = 1'b1;
        res_top   = rdata;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_SRCH: begin
        // rdata holds the word at idx_r; the next read is issued alongside.
        if (rdata == key_r) begin
          pos_nxt   = idx_inc;
          state_nxt = S_RESP;
        end else if (idx_inc == cnt_r) begin
          pos_nxt   = '0;
          state_nxt = S_RESP;
        end else begin
          re      = 1'b1;
          raddr   = idx_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_RV_A: begin
        tmp_nxt   = rdata;
        re        = 1'b1;
        raddr     = hi_r;
        state_nxt = S_RV_B;
      end
      S_RV_B: begin
        we        = 1'b1;
        waddr     = idx_r;
        wdata     = rdata;
        state_nxt = S_RV_C;
      end
      S_RV_C: begin
        we      = 1'b1;
        waddr   = hi_r;
        wdata   = tmp_r;
        idx_nxt = idx_r + 1'b1;
        hi_nxt  = hi_r - 1'b1;
        // Continue while the next low index stays below the next high index.
        if (lo_plus2 < {1'b0, hi_r}) begin
          re        = 1'b1;
          raddr     = idx_r + 1'b1;
          state_nxt = S_RV_A;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
        res_pos   = pos_r;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    hi_r  <= hi_nxt;
    key_r <= key_nxt;
    tmp_r <= tmp_nxt;
    pos_r <= pos_nxt;
  end

  // Count and position report modulo 256.
  assign res_pos_ext = {8'b0, res_pos};
  assign res_cnt_ext = {8'b0, cnt_nxt};

  assign res.status    = res_status;
  assign res.top_value = res_top;
  assign res.position  = res_pos_ext[7:0];
  assign res.count     = res_cnt_ext[7:0];

  lss_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {6'b0, out_res.count, out_res.position, out_res.top_value,
                      out_res.status};

endmodule
